// ----- rtl/ppd_pkg.sv -----
// Package: types and constants for the point-to-polyline distance block.
package ppd_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS + 1;
    localparam int BEST_BITS  = 2 * COORD_BITS + 3;
    localparam int DIST_BITS  = 25;
    localparam int QUO_BITS   = SQ_BITS;
    // bits of dot scanned by the multiply-divide, one per cycle
    localparam int NUM_BITS   = SQ_BITS;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
    localparam int ROOT_BITS  = (BEST_BITS + 1) / 2;
    localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS + 1);
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic                         first_vertex;
        logic                         last_vertex;
    } ppd_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 no_segment;
    } ppd_out_t;

    // Classified job passed from front to back.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         has_seg;
        logic                         restart;
        logic                         last;
    } ppd_job_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SQ1, ST_SQ2, ST_CLASS, ST_DIV,
        ST_UPD, ST_SQRT, ST_OUT
    } ppd_state_t;

endpackage

// ----- rtl/point_to_polyline_distance.sv -----
// Top level: least distance from a query point to a streamed polyline.
//
// Input channel s_*: one vertex per item, with the query point and the
// first/last markers. Result channel m_*: one item per polyline, issued
// on the item marked last, carrying floor(sqrt(min squared distance)) and
// a no_segment flag for single-vertex polylines.
// A front stage pairs each vertex with the previous one and pushes a job
// into a two-entry queue; the back stage works one job at a time.
// Back stage per vertex: a vertex that opens a polyline goes from idle
// to the minimum update. A segment passes the difference, squaring and
// classify states; if its projection clamps or it has zero length it goes
// to the update, else a radix-2 multiply-divide forms floor(dot^2/len2),
// one of the 51 bits of dot per cycle. The last vertex adds a bit-serial
// square root and a load of the output register; jobs wait in the queue.
// Reset (aresetn low, synchronous) empties the queue, drops the previous
// vertex and clears the running minimum.
// When the receiver stalls the result waits in the output register; the
// back stage stalls only when a second result is ready, and the queue keeps
// taking vertices until full.
module point_to_polyline_distance
    import ppd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ppd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ppd_out_t m_data
);

    logic     job_valid, job_ready;
    ppd_job_t job_data;

    ppd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data)
    );

    ppd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ----- rtl/ppd_front.sv -----
// Front end: accept vertices, pair them with the previous vertex, queue jobs.
module ppd_front
    import ppd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ppd_in_t  s_data,
    output logic     job_valid,
    input  logic     job_ready,
    output ppd_job_t job_data
);

    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic have_prev_reg;
    ppd_job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wr_ptr_reg, rd_ptr_reg;
    logic push, pop;
    ppd_job_t job_new;

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job_data  = q_reg[rd_ptr_reg];

    // Build the job from the previous vertex and the new item.
    always_comb begin
        job_new.ax      = prev_x_reg;
        job_new.ay      = prev_y_reg;
        job_new.bx      = s_data.vertex_x;
        job_new.by      = s_data.vertex_y;
        job_new.px      = s_data.query_x;
        job_new.py      = s_data.query_y;
        job_new.restart = s_data.first_vertex || !have_prev_reg;
        job_new.has_seg = !job_new.restart;
        job_new.last    = s_data.last_vertex;
    end

    // Advance the queue and the previous vertex.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= job_new;
                wr_ptr_reg        <= !wr_ptr_reg;
                prev_x_reg        <= s_data.vertex_x;
                prev_y_reg        <= s_data.vertex_y;
                have_prev_reg     <= !s_data.last_vertex;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/ppd_back.sv -----
// Back end: segment distance, running minimum, divider and square root.
module ppd_back
    import ppd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     job_valid,
    output logic     job_ready,
    input  ppd_job_t job_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ppd_out_t m_data
);

    ppd_state_t state_reg, state_next;
    ppd_job_t job_reg;
    logic signed [DIFF_BITS-1:0] dx_reg, dy_reg, ux_reg, uy_reg, vx_reg, vy_reg;
    logic [SQ_BITS-1:0] len2_reg, ap2_reg, bp2_reg;
    logic signed [SQ_BITS:0] dot_reg;
    logic [SQ_BITS-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [SQ_BITS-1:0] s0_reg;
    logic [BEST_BITS-1:0] best_reg, d2_reg;
    logic seen_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [SQ_BITS:0] rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic [BEST_BITS:0] sv_reg;
    logic [BEST_BITS:0] root_reg;
    logic [BEST_BITS+1:0] bit_reg;
    logic [SQRT_CNT_BITS-1:0] scnt_reg;
    logic out_valid_reg;
    ppd_out_t out_reg;

    logic [SQ_BITS+1:0] step_sum, len_x1, len_x2;
    logic [SQ_BITS:0] rem_step;
    logic [QUO_BITS-1:0] quo_sh, quo_step;
    logic [BEST_BITS+1:0] trial;
    logic [SQ_BITS-1:0] dot_u;

    function automatic logic [SQ_BITS-1:0] sqr(input logic signed [DIFF_BITS-1:0] v);
        logic [DIFF_BITS-1:0] a;
        a = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
        return SQ_BITS'(a * a);
    endfunction

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign dot_u     = SQ_BITS'(dot_reg);
    assign len_x1    = (SQ_BITS+2)'(len2_reg);
    assign len_x2    = {1'b0, len2_reg, 1'b0};
    assign trial     = (BEST_BITS+2)'(root_reg) + bit_reg;

    // Multiply-divide step: fold in one bit of dot, then reduce by len2 at most twice.
    always_comb begin
        step_sum = {rem_reg, 1'b0} + (num_reg[NUM_BITS-1] ? (SQ_BITS+2)'(dot_u) : '0);
        quo_sh   = {quo_reg[QUO_BITS-2:0], 1'b0};
        priority if (step_sum >= len_x2) begin
            rem_step = (SQ_BITS+1)'(step_sum - len_x2);
            quo_step = quo_sh + QUO_BITS'(2);
        end else if (step_sum >= len_x1) begin
            rem_step = (SQ_BITS+1)'(step_sum - len_x1);
            quo_step = quo_sh + QUO_BITS'(1);
        end else begin
            rem_step = (SQ_BITS+1)'(step_sum);
            quo_step = quo_sh;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) state_next = job_data.has_seg ? ST_DIFF : ST_UPD;
            ST_DIFF:  state_next = ST_SQ1;
            ST_SQ1:   state_next = ST_SQ2;
            ST_SQ2:   state_next = ST_CLASS;
            ST_CLASS: begin
                if (len2_reg == '0 || dot_reg <= 0 || dot_u >= len2_reg) state_next = ST_UPD;
                else state_next = ST_DIV;
            end
            ST_DIV:   if (dcnt_reg == DIV_CNT_BITS'(NUM_BITS - 1)) state_next = ST_UPD;
            ST_UPD: begin
                if (!job_reg.last) state_next = ST_IDLE;
                else if (seen_reg || job_reg.has_seg) state_next = ST_SQRT;
                else state_next = ST_OUT;
            end
            ST_SQRT:  if (scnt_reg == SQRT_CNT_BITS'(ROOT_BITS - 1)) state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '1;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // Load a new result, or drop the one taken by the receiver.
            if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    job_reg <= job_data;
                    if (job_valid && job_data.restart) begin
                        best_reg <= '1;
                        seen_reg <= 1'b0;
                    end
                end
                ST_DIFF: begin
                    dx_reg <= DIFF_BITS'(job_reg.bx) - DIFF_BITS'(job_reg.ax);
                    dy_reg <= DIFF_BITS'(job_reg.by) - DIFF_BITS'(job_reg.ay);
                    ux_reg <= DIFF_BITS'(job_reg.px) - DIFF_BITS'(job_reg.ax);
                    uy_reg <= DIFF_BITS'(job_reg.py) - DIFF_BITS'(job_reg.ay);
                    vx_reg <= DIFF_BITS'(job_reg.px) - DIFF_BITS'(job_reg.bx);
                    vy_reg <= DIFF_BITS'(job_reg.py) - DIFF_BITS'(job_reg.by);
                end
                ST_SQ1: begin
                    t0_reg <= sqr(dx_reg);
                    t1_reg <= sqr(ux_reg);
                    t2_reg <= sqr(vx_reg);
                    s0_reg <= SQ_BITS'(ux_reg * dx_reg);
                end
                ST_SQ2: begin
                    len2_reg <= t0_reg + sqr(dy_reg);
                    ap2_reg  <= t1_reg + sqr(uy_reg);
                    bp2_reg  <= t2_reg + sqr(vy_reg);
                    dot_reg  <= (SQ_BITS+1)'(s0_reg) + (SQ_BITS+1)'(SQ_BITS'(uy_reg * dy_reg));
                end
                ST_CLASS: begin
                    if (len2_reg == '0 || dot_reg <= 0) begin
                        d2_reg <= BEST_BITS'(ap2_reg);
                    end else if (dot_u >= len2_reg) begin
                        d2_reg <= BEST_BITS'(bp2_reg);
                    end else begin
                        num_reg  <= dot_u;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        dcnt_reg <= '0;
                    end
                end
                ST_DIV: begin
                    // One bit of dot per cycle, quotient of dot^2 / len2.
                    num_reg  <= num_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    if (dcnt_reg == DIV_CNT_BITS'(NUM_BITS - 1)) begin
                        d2_reg <= (quo_step > ap2_reg) ? '0 :
                            BEST_BITS'(ap2_reg - quo_step);
                    end
                end
                ST_UPD: begin
                    if (job_reg.has_seg) begin
                        seen_reg <= 1'b1;
                        if (d2_reg < best_reg) begin
                            best_reg <= d2_reg;
                            sv_reg   <= {1'b0, d2_reg};
                        end else begin
                            sv_reg <= {1'b0, best_reg};
                        end
                    end else begin
                        sv_reg <= {1'b0, best_reg};
                    end
                    root_reg <= '0;
                    bit_reg  <= (BEST_BITS+2)'(1) << (2 * (ROOT_BITS - 1));
                    scnt_reg <= '0;
                end
                ST_SQRT: begin
                    // One result bit per cycle.
                    scnt_reg <= scnt_reg + 1'b1;
                    bit_reg  <= bit_reg >> 2;
                    if ((BEST_BITS+2)'(sv_reg) >= trial) begin
                        sv_reg   <= sv_reg - (BEST_BITS+1)'(trial);
                        root_reg <= (root_reg >> 1) + (BEST_BITS+1)'(bit_reg);
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        if (seen_reg) begin
                            out_reg.distance   <= (root_reg > (BEST_BITS+1)'(DIST_MAX)) ?
                                DIST_MAX : DIST_BITS'(root_reg);
                            out_reg.no_segment <= 1'b0;
                        end else begin
                            out_reg.distance   <= DIST_MAX;
                            out_reg.no_segment <= 1'b1;
                        end
                        best_reg <= '1;
                        seen_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
